### sv/hex_grid_isolated_hit_finder_unit_assert.svh
`ifndef HEX_GRID_ISOLATED_HIT_FINDER_UNIT_ASSERT_SVH
`define HEX_GRID_ISOLATED_HIT_FINDER_UNIT_ASSERT_SVH

// Condition that must hold at every edge outside reset.
`define HGIH_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Trigger in one cycle implies a result in the next cycle.
`define HGIH_ASSERT_NEXT(label, trig, res, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (res)) else $error(msg);

`endif

### sv/hgih_pkg.sv
package hgih_pkg;

  localparam int GRID_X_DEF      = 128;
  localparam int GRID_Y_DEF      = 128;
  localparam int MAX_REPORTS_DEF = 64;
  localparam int ADC_BITS_DEF    = 12;

  localparam logic [1:0] CFG_SCAN_X = 2'd0;
  localparam logic [1:0] CFG_SCAN_Y = 2'd1;
  localparam logic [1:0] CFG_SUBDET = 2'd2;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_SCAN  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic store;
    logic scan_init;
    logic rd;
    logic cap_center;
    logic k_inc;
    logic record;
    logic next_cell;
    logic emit_rd;
    logic emit_ld;
    logic emit_inc;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic nbr_out;
    logic rd_zero;
    logic k_zero;
    logic k_six;
    logic scan_empty;
    logic cell_last;
    logic out_free;
    logic emit_last;
    logic clr_last;
  } sts_t;

  // Neighbor offsets, step 1..6; step 0 is the cell itself. -1 is 2'b11.
  function automatic logic [1:0] nb_dx(input logic [2:0] k);
    logic [1:0] d;
    case (k)
      3'd1: d = 2'b01;
      3'd2: d = 2'b00;
      3'd3: d = 2'b11;
      3'd4: d = 2'b11;
      3'd5: d = 2'b00;
      3'd6: d = 2'b01;
      default: d = 2'b00;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] nb_dy(input logic [2:0] k);
    logic [1:0] d;
    case (k)
      3'd1: d = 2'b00;
      3'd2: d = 2'b01;
      3'd3: d = 2'b01;
      3'd4: d = 2'b00;
      3'd5: d = 2'b11;
      3'd6: d = 2'b11;
      default: d = 2'b00;
    endcase
    return d;
  endfunction

endpackage

### sv/hgih_datapath.sv
`include "hex_grid_isolated_hit_finder_unit_assert.svh"

module hgih_datapath import hgih_pkg::*; #(
  parameter int GRID_X      = GRID_X_DEF,
  parameter int GRID_Y      = GRID_Y_DEF,
  parameter int MAX_REPORTS = MAX_REPORTS_DEF,
  parameter int ADC_BITS    = ADC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic [1:0]  subdetector,
  input  logic [7:0]  hit_x,
  input  logic [7:0]  hit_y,
  input  logic [11:0] hit_adc,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        found,
  output logic [6:0]  cell_x,
  output logic [6:0]  cell_y,
  output logic [11:0] cell_adc,
  output logic        overflow,
  output logic        last
);

  localparam int XW = $clog2(GRID_X);
  localparam int YW = $clog2(GRID_Y);
  localparam int AW = XW + YW;
  localparam int NW = (MAX_REPORTS > 1) ? $clog2(MAX_REPORTS) : 1;
  localparam int CW = $clog2(MAX_REPORTS + 1);
  localparam int EW = XW + YW + ADC_BITS;

  logic [7:0] scan_x_lim;
  logic [7:0] scan_y_lim;
  logic [1:0] acc_sub;

  logic [ADC_BITS-1:0] grid [2**AW];
  logic [ADC_BITS-1:0] rd_data;
  logic [EW-1:0]       rbuf [MAX_REPORTS];
  logic [EW-1:0]       rbuf_q;

  logic [XW-1:0]       x;
  logic [YW-1:0]       y;
  logic [2:0]          k;
  logic [ADC_BITS-1:0] center;
  logic [CW-1:0]       n;
  logic                over;
  logic [NW-1:0]       eidx;
  logic [AW-1:0]       clr_addr;

  logic [8:0]          xl, yl;
  logic [1:0]          dx, dy;
  logic [XW:0]         nx;
  logic [YW:0]         ny;
  logic                hit_ok;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [ADC_BITS-1:0] wdata;
  logic                y_end;
  logic                n_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_x_lim <= 8'd96;
      scan_y_lim <= 8'd96;
      acc_sub    <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCAN_X: scan_x_lim <= cfg_data;
        CFG_SCAN_Y: scan_y_lim <= cfg_data;
        CFG_SUBDET: acc_sub    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign hit_ok = (subdetector == acc_sub) && (hit_x != 8'd0) && (hit_y != 8'd0) &&
                  ({1'b0, hit_x} <= 9'(GRID_X)) && ({1'b0, hit_y} <= 9'(GRID_Y));

  assign we    = cmd.clr_step | (cmd.store & hit_ok);
  assign waddr = cmd.clr_step ? clr_addr :
                 {XW'(hit_x - 8'd1), YW'(hit_y - 8'd1)};
  assign wdata = cmd.clr_step ? '0 : ADC_BITS'(hit_adc);

  assign dx = nb_dx(k);
  assign dy = nb_dy(k);
  assign nx = {1'b0, x} + {{(XW-1){dx[1]}}, dx};
  assign ny = {1'b0, y} + {{(YW-1){dy[1]}}, dy};

  always_ff @(posedge clk) begin
    if (we) grid[waddr] <= wdata;
    if (cmd.rd) rd_data <= grid[{nx[XW-1:0], ny[YW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clr_step) clr_addr <= clr_addr + AW'(1);
  end

  // Limits above the grid size clamp to it
  assign xl = ({1'b0, scan_x_lim} > 9'(GRID_X)) ? 9'(GRID_X) : {1'b0, scan_x_lim};
  assign yl = ({1'b0, scan_y_lim} > 9'(GRID_Y)) ? 9'(GRID_Y) : {1'b0, scan_y_lim};

  assign y_end  = (9'(y) + 9'd1) == yl;
  assign n_full = (n == CW'(MAX_REPORTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      x    <= '0;
      y    <= '0;
      k    <= '0;
      n    <= '0;
      over <= 1'b0;
      eidx <= '0;
    end else begin
      if (cmd.scan_init) begin
        x    <= '0;
        y    <= '0;
        k    <= '0;
        n    <= '0;
        over <= 1'b0;
        eidx <= '0;
      end
      if (cmd.k_inc) k <= k + 3'd1;
      if (cmd.next_cell) begin
        k <= '0;
        if (y_end) begin
          y <= '0;
          x <= x + XW'(1);
        end else begin
          y <= y + YW'(1);
        end
      end
      if (cmd.record) begin
        if (n_full) over <= 1'b1;
        else n <= n + CW'(1);
      end
      if (cmd.emit_inc) eidx <= eidx + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_center) center <= rd_data;
    if (cmd.record && !n_full) rbuf[n[NW-1:0]] <= {x, y, center};
    if (cmd.emit_rd) rbuf_q <= rbuf[eidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      found    <= (n != '0);
      cell_x   <= (n != '0) ? 7'(rbuf_q[EW-1 -: XW]) : 7'd0;
      cell_y   <= (n != '0) ? 7'(rbuf_q[ADC_BITS +: YW]) : 7'd0;
      cell_adc <= (n != '0) ? 12'(rbuf_q[ADC_BITS-1:0]) : 12'd0;
      overflow <= over;
      last     <= sts.emit_last;
    end
  end

  always_comb begin
    sts.nbr_out    = (nx >= (XW+1)'(GRID_X)) || (ny >= (YW+1)'(GRID_Y));
    sts.rd_zero    = (rd_data == '0);
    sts.k_zero     = (k == 3'd0);
    sts.k_six      = (k == 3'd6);
    sts.scan_empty = (xl == 9'd0) || (yl == 9'd0);
    sts.cell_last  = y_end && ((9'(x) + 9'd1) == xl);
    sts.out_free   = !out_valid || !out_stall;
    sts.emit_last  = (n == '0) || ((CW'(eidx) + CW'(1)) == n);
    sts.clr_last   = (clr_addr == '1);
  end

  `HGIH_ASSERT(a_n_bound, n <= CW'(MAX_REPORTS), "report count beyond capacity")
  `HGIH_ASSERT(a_over_full, !over || n_full, "overflow set before buffer full")
  `HGIH_ASSERT_NEXT(a_over_set, cmd.record && n_full && !cmd.scan_init, over,
                    "dropped isolated cell not flagged")

endmodule

### sv/hgih_ctrl.sv
module hgih_ctrl import hgih_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic mode,
  input  sts_t sts,
  output logic in_stall,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (mode == MODE_STORE) begin
            cmd.store = 1'b1;
          end else if (mode == MODE_SCAN) begin
            cmd.scan_init = 1'b1;
            state_next = sts.scan_empty ? ST_EMIT_RD : ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        if (!sts.k_zero && sts.nbr_out) begin
          // neighbor off the grid is empty
          if (sts.k_six) begin
            cmd.record    = 1'b1;
            cmd.next_cell = 1'b1;
            state_next = sts.cell_last ? ST_EMIT_RD : ST_SCAN_RD;
          end else begin
            cmd.k_inc = 1'b1;
          end
        end else begin
          cmd.rd = 1'b1;
          state_next = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (sts.k_zero) begin
          if (sts.rd_zero) begin
            cmd.next_cell = 1'b1;
            state_next = sts.cell_last ? ST_EMIT_RD : ST_SCAN_RD;
          end else begin
            cmd.cap_center = 1'b1;
            cmd.k_inc      = 1'b1;
            state_next = ST_SCAN_RD;
          end
        end else if (!sts.rd_zero) begin
          cmd.next_cell = 1'b1;
          state_next = sts.cell_last ? ST_EMIT_RD : ST_SCAN_RD;
        end else if (sts.k_six) begin
          cmd.record    = 1'b1;
          cmd.next_cell = 1'b1;
          state_next = sts.cell_last ? ST_EMIT_RD : ST_SCAN_RD;
        end else begin
          cmd.k_inc = 1'b1;
          state_next = ST_SCAN_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          if (sts.emit_last) begin
            state_next = ST_CLEAR;
          end else begin
            cmd.emit_inc = 1'b1;
            state_next = ST_EMIT_RD;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### sv/hex_grid_isolated_hit_finder_unit.sv
// Isolated hit finder on a hexagonal grid.
// Input channel (in_valid/in_stall): mode 0 stores one hit (no result);
// mode 1 ends the frame, scans the configured rectangle and reports
// isolated cells.
// Output channel (out_valid/out_stall): one item per isolated cell in scan
// order (first coordinate outer), up to MAX_REPORTS, overflow set on all of
// them if more were found, last on the final one. With none found a single
// item with found=0 and last=1 is sent.
// Config: cfg_we/cfg_index/cfg_data, written while idle.
// Hit stores run at one item per cycle. The scan reads the grid once per
// cell and per on-grid neighbor up to the first filled one, so an empty
// cell needs one read. Emit reads and then loads each item, waiting out
// receiver stall. The grid is then wiped one word per cycle, over all
// 2**(clog2(GRID_X)+clog2(GRID_Y)) words (16384 by default), in_stall high.
// Reset: synchronous; the same wipe runs after reset before any item.
// A stalled output holds its item; the block waits in emit until it is taken.
module hex_grid_isolated_hit_finder_unit import hgih_pkg::*; #(
  parameter int GRID_X      = GRID_X_DEF,
  parameter int GRID_Y      = GRID_Y_DEF,
  parameter int MAX_REPORTS = MAX_REPORTS_DEF,
  parameter int ADC_BITS    = ADC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [1:0]  subdetector,
  input  logic [7:0]  hit_x,
  input  logic [7:0]  hit_y,
  input  logic [11:0] hit_adc,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [6:0]  cell_x,
  output logic [6:0]  cell_y,
  output logic [11:0] cell_adc,
  output logic        overflow,
  output logic        last
);

  cmd_t cmd;
  sts_t sts;

  hgih_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  hgih_datapath #(
    .GRID_X      (GRID_X),
    .GRID_Y      (GRID_Y),
    .MAX_REPORTS (MAX_REPORTS),
    .ADC_BITS    (ADC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .subdetector (subdetector),
    .hit_x       (hit_x),
    .hit_y       (hit_y),
    .hit_adc     (hit_adc),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .found       (found),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .cell_adc    (cell_adc),
    .overflow    (overflow),
    .last        (last)
  );

endmodule

### sim/hex_grid_isolated_hit_finder_unit_test.sv
module hex_grid_isolated_hit_finder_unit_test import hgih_pkg::*; ();

  typedef struct packed {
    logic        found;
    logic [6:0]  cx;
    logic [6:0]  cy;
    logic [11:0] adc;
    logic        ovf;
    logic        last;
  } report_t;

  typedef struct packed {
    logic        mode;
    logic [1:0]  sub;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [11:0] adc;
    logic        typed;
    report_t     rep;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  logic [1:0] subdetector = '0;
  logic [7:0] hit_x = '0;
  logic [7:0] hit_y = '0;
  logic [11:0] hit_adc = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found;
  logic [6:0] cell_x;
  logic [6:0] cell_y;
  logic [11:0] cell_adc;
  logic overflow;
  logic last;

  hex_grid_isolated_hit_finder_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .subdetector(subdetector), .hit_x(hit_x), .hit_y(hit_y),
    .hit_adc(hit_adc),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .cell_x(cell_x), .cell_y(cell_y), .cell_adc(cell_adc),
    .overflow(overflow), .last(last)
  );

  always #5 clk = ~clk;

  // local copy of the block state
  logic [11:0] adc_grid [0:127][0:127];
  logic [7:0] scan_x_lim = 8'd96;
  logic [7:0] scan_y_lim = 8'd96;
  logic [1:0] accept_sub = 2'd1;

  report_t pending_reports[$];
  int mismatches = 0;
  bit quiet = 0;
  bit hold_req = 0;

  function automatic logic [11:0] grid_at(int x, int y);
    if (x < 0 || y < 0 || x > 127 || y > 127) return 12'd0;
    return adc_grid[x][y];
  endfunction

  function automatic bit lonely(int x, int y);
    if (grid_at(x, y) == 0) return 0;
    return grid_at(x+1, y) == 0 && grid_at(x, y+1) == 0 && grid_at(x-1, y+1) == 0 &&
           grid_at(x-1, y) == 0 && grid_at(x, y-1) == 0 && grid_at(x+1, y-1) == 0;
  endfunction

  task automatic clear_grid();
    for (int i = 0; i < 128; i++)
      for (int j = 0; j < 128; j++)
        adc_grid[i][j] = '0;
  endtask

  task automatic apply_item(logic m, logic [1:0] s, logic [7:0] x, logic [7:0] y,
                            logic [11:0] a, bit typed, report_t rep);
    int xl, yl, n;
    bit over;
    report_t r, found_q[$];
    over = 0;
    if (m == MODE_STORE) begin
      if (s == accept_sub && x >= 1 && x <= 128 && y >= 1 && y <= 128)
        adc_grid[x-1][y-1] = a;
      return;
    end
    xl = scan_x_lim > 128 ? 128 : scan_x_lim;
    yl = scan_y_lim > 128 ? 128 : scan_y_lim;
    n = 0;
    for (int i = 0; i < xl; i++)
      for (int j = 0; j < yl; j++) begin
        if (!lonely(i, j)) continue;
        if (n >= 64) begin
          over = 1;
          continue;
        end
        r = '{1'b1, i[6:0], j[6:0], grid_at(i, j), 1'b0, 1'b0};
        found_q.push_back(r);
        n++;
      end
    clear_grid();
    if (n == 0) found_q.push_back('{1'b0, 7'd0, 7'd0, 12'd0, 1'b0, 1'b1});
    else begin
      foreach (found_q[k]) found_q[k].ovf = over;
      found_q[n-1].last = 1'b1;
    end
    if (typed) pending_reports.push_back(rep);
    else foreach (found_q[k]) pending_reports.push_back(found_q[k]);
  endtask

  // result checker
  always @(posedge clk) begin
    report_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{found, cell_x, cell_y, cell_adc, overflow, last};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report %p", got);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("report mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // receiver stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (3000) @(negedge clk);
        hold_req = 0;
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_item(logic m, logic [1:0] s, logic [7:0] x, logic [7:0] y,
                           logic [11:0] a, bit typed = 0, report_t rep = '0);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    mode = m; subdetector = s; hit_x = x; hit_y = y; hit_adc = a;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    apply_item(m, s, x, y, a, typed, rep);
  endtask

  task automatic wait_idle();
    int calm;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    calm = 0;
    while (calm < 4) begin
      @(posedge clk);
      calm = in_stall ? 0 : calm + 1;
    end
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(posedge clk);
    case (idx)
      CFG_SCAN_X: scan_x_lim = val;
      CFG_SCAN_Y: scan_y_lim = val;
      CFG_SUBDET: accept_sub = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_phase(logic [7:0] sx, logic [7:0] sy, logic [1:0] sd);
    wait_idle();
    cfg_write(CFG_SCAN_X, sx);
    cfg_write(CFG_SCAN_Y, sy);
    cfg_write(CFG_SUBDET, sd);
  endtask

  task automatic run_frame();
    int n, xr, yr, r;
    logic [1:0] s;
    logic [11:0] a;
    xr = scan_x_lim > 127 ? 128 : (scan_x_lim == 0 ? 2 : scan_x_lim + 1);
    yr = scan_y_lim > 127 ? 128 : (scan_y_lim == 0 ? 2 : scan_y_lim + 1);
    n = $urandom_range(8, 25);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) send_item(MODE_STORE, 2'($urandom), 8'($urandom), 8'($urandom),
                            12'($urandom));
      else begin
        s = (r == 1) ? 2'($urandom) : accept_sub;
        a = (r == 2) ? 12'd0 : 12'($urandom_range(1, 4095));
        send_item(MODE_STORE, s, 8'($urandom_range(1, xr)), 8'($urandom_range(1, yr)), a);
      end
    end
    send_item(MODE_SCAN, 2'($urandom), 8'($urandom), 8'($urandom), 12'($urandom));
  endtask

  dir_row_t dir_rows[$];

  initial begin
    dir_rows = '{
      '{MODE_SCAN, 2'd0, 8'd0, 8'd0, 12'd0, 1'b1, '{1'b0, 7'd0, 7'd0, 12'd0, 1'b0, 1'b1}},
      '{MODE_STORE, 2'd1, 8'd1,   8'd1,   12'd4095, 1'b0, '0},
      '{MODE_SCAN, 2'd3, 8'd255, 8'd255, 12'd4095, 1'b1,
        '{1'b1, 7'd0, 7'd0, 12'd4095, 1'b0, 1'b1}},
      '{MODE_STORE, 2'd1, 8'd96,  8'd96,  12'd1,    1'b0, '0},
      '{MODE_STORE, 2'd2, 8'd5,   8'd5,   12'd7,    1'b0, '0},
      '{MODE_STORE, 2'd0, 8'd7,   8'd7,   12'd7,    1'b0, '0},
      '{MODE_STORE, 2'd1, 8'd0,   8'd3,   12'd9,    1'b0, '0},
      '{MODE_STORE, 2'd1, 8'd3,   8'd0,   12'd9,    1'b0, '0},
      '{MODE_STORE, 2'd1, 8'd129, 8'd5,   12'd9,    1'b0, '0},
      '{MODE_STORE, 2'd1, 8'd5,   8'd129, 12'd9,    1'b0, '0},
      '{MODE_STORE, 2'd1, 8'd255, 8'd255, 12'd9,    1'b0, '0},
      '{MODE_SCAN, 2'd0, 8'd0, 8'd0, 12'd0, 1'b1, '{1'b1, 7'd95, 7'd95, 12'd1, 1'b0, 1'b1}},
      '{MODE_STORE, 2'd1, 8'd10,  8'd10,  12'd5,    1'b0, '0},
      '{MODE_STORE, 2'd1, 8'd11,  8'd10,  12'd6,    1'b0, '0},
      '{MODE_STORE, 2'd1, 8'd20,  8'd20,  12'd9,    1'b0, '0},
      '{MODE_STORE, 2'd1, 8'd20,  8'd20,  12'd0,    1'b0, '0},
      '{MODE_STORE, 2'd1, 8'd30,  8'd30,  12'd3,    1'b0, '0},
      '{MODE_STORE, 2'd1, 8'd31,  8'd29,  12'd2,    1'b0, '0},
      '{MODE_STORE, 2'd1, 8'd40,  8'd42,  12'd2730, 1'b0, '0},
      '{MODE_STORE, 2'd1, 8'd128, 8'd128, 12'd1365, 1'b0, '0},
      '{MODE_SCAN,  2'd1, 8'd0,   8'd0,   12'd0,    1'b0, '0}
    };
    clear_grid();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait_idle();
    foreach (dir_rows[i])
      send_item(dir_rows[i].mode, dir_rows[i].sub, dir_rows[i].x, dir_rows[i].y,
                dir_rows[i].adc, dir_rows[i].typed, dir_rows[i].rep);

    // grid corners at full size, foreign sub-detector ignored
    set_phase(8'd128, 8'd128, 2'd2);
    send_item(MODE_STORE, 2'd2, 8'd128, 8'd128, 12'd77);
    send_item(MODE_STORE, 2'd1, 8'd64, 8'd64, 12'd12);
    send_item(MODE_STORE, 2'd2, 8'd128, 8'd1, 12'd2048);
    send_item(MODE_STORE, 2'd2, 8'd1, 8'd128, 12'd1);
    send_item(MODE_SCAN, 2'd0, 8'd0, 8'd0, 12'd0);

    // zero scan width finds nothing
    set_phase(8'd0, 8'd50, 2'd1);
    send_item(MODE_STORE, 2'd1, 8'd1, 8'd1, 12'd5);
    send_item(MODE_SCAN, 2'd0, 8'd0, 8'd0, 12'd0, 1, '{1'b0, 7'd0, 7'd0, 12'd0, 1'b0, 1'b1});

    set_phase(8'd12, 8'd12, 2'd1);
    repeat (4) run_frame();

    // more isolated cells than can be reported, with the receiver held off
    set_phase(8'd20, 8'd20, 2'd2);
    hold_req = 1;
    for (int i = 0; i < 10; i++)
      for (int j = 0; j < 10; j++)
        send_item(MODE_STORE, 2'd2, 8'(2*i+1), 8'(2*j+1), 12'($urandom_range(1, 4095)));
    send_item(MODE_SCAN, 2'd2, 8'd0, 8'd0, 12'd0);
    repeat (2) run_frame();

    set_phase(8'd1, 8'd1, 2'd1);
    repeat (2) run_frame();
    set_phase(8'd128, 8'd128, 2'd2);
    run_frame();
    set_phase(8'd8, 8'd40, 2'd0);
    repeat (2) run_frame();
    set_phase(8'd255, 8'd0, 2'd3);
    run_frame();
    set_phase(8'($urandom_range(1, 24)), 8'($urandom_range(1, 24)),
              2'($urandom_range(1, 2)));
    repeat (4) run_frame();

    set_phase(8'd10, 8'd10, 2'd1);
    quiet = 1;
    repeat (3) run_frame();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #50000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
